// ===== rtl/core/direct_mapped_writeback_cache_top_defines.svh =====
// assertion macros for the direct-mapped write-back cache
// no dependencies; included by direct_mapped_writeback_cache_top.sv
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_TOP_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define DMWBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmwbc assertion failed");
// next-cycle implication, disabled during reset
`define DMWBC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmwbc assertion failed");
`else
`define DMWBC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DMWBC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/dmwbc_pkg.sv =====
// shared types and constants of the direct-mapped write-back cache
// no dependencies; imported by the top, ctrl and datapath modules
package dmwbc_pkg;

  localparam int ADDR_W      = 16;
  localparam int WORD_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int FUNC_W      = 2;

  localparam int BLOCK_BYTES = 16;
  localparam int WORD_BYTES  = 4;
  localparam int MEM_BYTES   = 65536;

  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int BSEL_W      = $clog2(WORD_BYTES);
  localparam int WSEL_W      = OFF_W - BSEL_W;
  localparam int BLOCK_W     = 8 * BLOCK_BYTES;
  localparam int MEM_BLOCKS  = MEM_BYTES / BLOCK_BYTES;
  localparam int MEM_BLK_W   = $clog2(MEM_BLOCKS);

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_INVAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_READ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_READ  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_WRITE = 2'd3;

  localparam logic [CFG_W-1:0] MEM_READ_RST  = 16'd100;
  localparam logic [CFG_W-1:0] MEM_WRITE_RST = 16'd50;
  localparam logic [CFG_W-1:0] HIT_READ_RST  = 16'd1;
  localparam logic [CFG_W-1:0] HIT_WRITE_RST = 16'd1;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic fill;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic sweep_last;
  } status_t;

endpackage

// ===== rtl/core/direct_mapped_writeback_cache_top.sv =====
// top level of the direct-mapped write-back write-allocate cache with backing memory
// depends on dmwbc_pkg, dmwbc_ctrl, dmwbc_datapath and the defines header
//
// usage:
//   request channel: drive func, address and write_data with start high; the
//   transaction is taken at the clock edge where start is high and busy is low
//   result channel: done pulses for exactly one cycle with read_data, hit and
//   time_total; the receiver cannot stall, so each result must be taken then
//   config channel: cfg_valid with cfg_index and cfg_data; cfg_ready is always
//   high, so every cfg write outside reset lands on its edge (write only while idle)
// sequencing per function:
//   clear time counter / invalidate all: result in the cycle after the transaction,
//   and the next transaction may follow in the very next cycle
//   hit: registered tag and data ram read, then compare and update in the lookup
//   state, which registers the result; busy is high until that state ends
//   miss: a fill state follows the lookup for the backing ram read, busy still high
// reset: synchronous; after rst drops the backing store is swept to zero, one
//   block per cycle, 4096 blocks with busy high; config writes still accepted
`include "direct_mapped_writeback_cache_top_defines.svh"

module direct_mapped_writeback_cache_top import dmwbc_pkg::*; #(
  // power of two, 2 to 2048
  parameter int NUM_LINES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    func,
  input  logic [ADDR_W-1:0]    address,
  input  logic [WORD_W-1:0]    write_data,
  // result channel
  output logic                 done,
  output logic [WORD_W-1:0]    read_data,
  output logic                 hit,
  output logic [WORD_W-1:0]    time_total,
  // config channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  // registers accept a write every cycle outside reset
  assign cfg_ready = 1'b1;

  // sequencer: sweep after reset, then lookup and optional fill per read or write request
  dmwbc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // rams, line flags, time counter and result registers
  dmwbc_datapath #(.NUM_LINES(NUM_LINES)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .func       (func),
    .address    (address),
    .write_data (write_data),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .read_data  (read_data),
    .hit        (hit),
    .time_total (time_total)
  );

  // a read or write transaction always goes to the lookup step next
  `DMWBC_ASSERT_NXT(a_rw_to_lookup, clk, rst, start && !busy && (func == FUNC_READ || func == FUNC_WRITE), cmd.lookup)
  // a lookup ends in a result or in a fill
  `DMWBC_ASSERT_NXT(a_lookup_resolves, clk, rst, cmd.lookup, done || cmd.fill)
  // a fill always delivers its result
  `DMWBC_ASSERT_NXT(a_fill_done, clk, rst, cmd.fill, done && !hit)
  // no transaction is taken while the backing store sweep runs
  `DMWBC_ASSERT_IMP(a_sweep_busy, clk, rst, cmd.sweep, busy && !cmd.accept)

endmodule

// ===== rtl/core/dmwbc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module dmwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dmwbc_ctrl.sv =====
// request sequencer of the cache: sweep, idle, lookup and fill states
// depends on dmwbc_pkg
module dmwbc_ctrl import dmwbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  status_t           status,
  output cmd_t              cmd,
  output logic              busy
);

  localparam logic [1:0] ST_SWEEP  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_FILL   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && (func inside {FUNC_READ, FUNC_WRITE})) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = status.hit ? ST_IDLE : ST_FILL;
      end
      ST_FILL: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state != ST_IDLE);
  assign cmd.accept = (state == ST_IDLE) && start;
  assign cmd.lookup = (state == ST_LOOKUP);
  assign cmd.fill   = (state == ST_FILL);
  assign cmd.sweep  = (state == ST_SWEEP);

endmodule

// ===== rtl/core/dmwbc_datapath.sv =====
// cache datapath: tag, data and backing rams, line flags, timing counter, results
// depends on dmwbc_pkg and dmwbc_ram
module dmwbc_datapath import dmwbc_pkg::*; #(
  parameter int NUM_LINES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic [FUNC_W-1:0]    func,
  input  logic [ADDR_W-1:0]    address,
  input  logic [WORD_W-1:0]    write_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [WORD_W-1:0]    read_data,
  output logic                 hit,
  output logic [WORD_W-1:0]    time_total
);

  localparam int IDX_W = $clog2(NUM_LINES);
  localparam int TAG_W = ADDR_W - OFF_W - IDX_W;

  // latched request
  logic [FUNC_W-1:0] req_func;
  logic [ADDR_W-1:0] req_addr;
  logic [WORD_W-1:0] req_wdata;

  logic [IDX_W-1:0]     req_line;
  logic [TAG_W-1:0]     req_tag;
  logic [MEM_BLK_W-1:0] req_blk;
  logic [WSEL_W-1:0]    req_word_sel;
  logic [BSEL_W-1:0]    req_byte_sel;
  logic                 is_write;

  logic [CFG_W-1:0] mem_read_cycles;
  logic [CFG_W-1:0] mem_write_cycles;
  logic [CFG_W-1:0] hit_read_cycles;
  logic [CFG_W-1:0] hit_write_cycles;

  logic [NUM_LINES-1:0] valid_bits;
  logic [NUM_LINES-1:0] dirty_bits;
  logic [WORD_W-1:0]    time_cnt;
  logic [WORD_W-1:0]    time_next;
  logic [MEM_BLK_W-1:0] sweep_cnt;

  logic [IDX_W-1:0]     rd_line;
  logic [TAG_W-1:0]     tag_rd;
  logic [BLOCK_W-1:0]   data_rd;
  logic [BLOCK_W-1:0]   back_rd;
  logic                 tag_we;
  logic                 data_we;
  logic                 back_we;
  logic [MEM_BLK_W-1:0] back_waddr;
  logic [BLOCK_W-1:0]   back_wdata;

  logic                 line_hit;
  logic                 victim_wb;
  logic                 accept_mem;
  logic [BLOCK_W-1:0]   src_block;
  logic [BLOCK_W-1:0]   new_block;
  logic [WORD_W-1:0]    old_word;
  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    wr_word;
  logic [$clog2(WORD_W)-1:0] byte_shift;
  logic [CFG_W-1:0]     hit_cost;
  logic [CFG_W:0]       miss_cost;
  logic [WORD_W-1:0]    time_add;
  logic [WORD_W-1:0]    rd_result;

  assign req_line     = req_addr[OFF_W +: IDX_W];
  assign req_tag      = req_addr[ADDR_W-1 -: TAG_W];
  assign req_blk      = req_addr[OFF_W +: MEM_BLK_W];
  assign req_word_sel = req_addr[BSEL_W +: WSEL_W];
  assign req_byte_sel = req_addr[BSEL_W-1:0];
  assign is_write     = (req_func == FUNC_WRITE);
  assign accept_mem   = cmd.accept && (func inside {FUNC_READ, FUNC_WRITE});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_func  <= func;
      req_addr  <= address;
      req_wdata <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_read_cycles  <= MEM_READ_RST;
      mem_write_cycles <= MEM_WRITE_RST;
      hit_read_cycles  <= HIT_READ_RST;
      hit_write_cycles <= HIT_WRITE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MEM_READ:  mem_read_cycles  <= cfg_data;
        CFG_MEM_WRITE: mem_write_cycles <= cfg_data;
        CFG_HIT_READ:  hit_read_cycles  <= cfg_data;
        CFG_HIT_WRITE: hit_write_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  // rams: line tags, line data, backing store
  assign rd_line = cmd.accept ? address[OFF_W +: IDX_W] : req_line;

  dmwbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_LINES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (req_line),
    .wdata (req_tag),
    .raddr (rd_line),
    .rdata (tag_rd)
  );

  dmwbc_ram #(.WIDTH(BLOCK_W), .DEPTH(NUM_LINES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (req_line),
    .wdata (new_block),
    .raddr (rd_line),
    .rdata (data_rd)
  );

  dmwbc_ram #(.WIDTH(BLOCK_W), .DEPTH(MEM_BLOCKS)) u_back_ram (
    .clk   (clk),
    .we    (back_we),
    .waddr (back_waddr),
    .wdata (back_wdata),
    .raddr (req_blk),
    .rdata (back_rd)
  );

  assign line_hit  = valid_bits[req_line] && (tag_rd == req_tag);
  assign victim_wb = valid_bits[req_line] && dirty_bits[req_line];

  assign tag_we     = cmd.fill;
  assign data_we    = cmd.fill || (cmd.lookup && line_hit && is_write);
  assign back_we    = cmd.sweep || (cmd.lookup && !line_hit && victim_wb);
  assign back_waddr = cmd.sweep ? sweep_cnt : {tag_rd, req_line};
  assign back_wdata = cmd.sweep ? '0 : data_rd;

  // word select and byte merge
  assign src_block  = cmd.fill ? back_rd : data_rd;
  assign old_word   = src_block[WORD_W*req_word_sel +: WORD_W];
  assign byte_shift = {req_byte_sel, 3'b000};
  assign rd_word    = old_word >> byte_shift;
  assign wr_word    = (old_word & ~({WORD_W{1'b1}} << byte_shift)) | (req_wdata << byte_shift);
  assign rd_result  = is_write ? '0 : rd_word;

  always_comb begin
    new_block = src_block;
    if (is_write) begin
      new_block[WORD_W*req_word_sel +: WORD_W] = wr_word;
    end
  end

  // timing counter, one accumulate adder; the miss cost is summed separately
  assign hit_cost  = is_write ? hit_write_cycles : hit_read_cycles;
  assign miss_cost = {1'b0, mem_read_cycles} + (victim_wb ? {1'b0, mem_write_cycles} : '0);

  always_comb begin
    time_add = '0;
    if (cmd.lookup && !line_hit) begin
      time_add = {{(WORD_W-CFG_W-1){1'b0}}, miss_cost};
    end else if (cmd.lookup || cmd.fill) begin
      time_add = {{(WORD_W-CFG_W){1'b0}}, hit_cost};
    end
    time_next = time_cnt + time_add;
    if (cmd.accept && (func == FUNC_CLEAR)) begin
      time_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_cnt  <= '0;
      sweep_cnt <= '0;
    end else begin
      time_cnt <= time_next;
      if (cmd.sweep) sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      dirty_bits <= '0;
    end else if (cmd.accept && (func == FUNC_INVAL)) begin
      valid_bits <= '0;
      dirty_bits <= '0;
    end else if (cmd.fill) begin
      valid_bits[req_line] <= 1'b1;
      dirty_bits[req_line] <= is_write;
    end else if (cmd.lookup && line_hit && is_write) begin
      dirty_bits[req_line] <= 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.accept && !accept_mem) || (cmd.lookup && line_hit) || cmd.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      read_data <= '0;
      hit       <= 1'b0;
    end else if (cmd.lookup && line_hit) begin
      read_data <= rd_result;
      hit       <= 1'b1;
    end else if (cmd.fill) begin
      read_data <= rd_result;
      hit       <= 1'b0;
    end
  end

  assign time_total        = time_cnt;
  assign status.hit        = line_hit;
  assign status.sweep_last = (sweep_cnt == {MEM_BLK_W{1'b1}});

endmodule
